### sv/utdec_pkg.sv
// Shared types, constants and helpers of the UTF-8 to UCS-4 decoder.
package utdec_pkg;

   // Widths fixed by the payload fields.
   localparam int CP_WIDTH    = 31;
   localparam int COUNT_WIDTH = 17;

   // Largest value the code-point counter can hold.
   localparam int COUNT_LIMIT = 131071;

   // Default string length bound used for count saturation.
   localparam int MAX_STRING_BYTES_DEFAULT = 65536;

   // Replacement character after reset (U+FFFD).
   localparam logic [CP_WIDTH-1:0] REPLACEMENT_RESET = 31'd65533;

   // Lead byte classification masks and patterns.
   localparam logic [7:0] ASCII_MASK  = 8'h80;
   localparam logic [7:0] LEAD2_MASK  = 8'hE0;
   localparam logic [7:0] LEAD2_CODE  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK  = 8'hF0;
   localparam logic [7:0] LEAD3_CODE  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK  = 8'hF8;
   localparam logic [7:0] LEAD4_CODE  = 8'hF0;
   localparam logic [7:0] LEAD5_MASK  = 8'hFC;
   localparam logic [7:0] LEAD5_CODE  = 8'hF8;
   localparam logic [7:0] LEAD6_MASK  = 8'hFE;
   localparam logic [7:0] LEAD6_CODE  = 8'hFC;
   localparam logic [7:0] CONT_MASK   = 8'h3F;

   // One byte of the input stream.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_payload_type;

   // One decoded result.
   typedef struct packed {
      logic [CP_WIDTH-1:0]    code_point;
      logic                   incomplete;
      logic [2:0]             partial_bytes;
      logic [COUNT_WIDTH-1:0] total_chars;
      logic                   last;
   } rsp_payload_type;

   // Sequence state exposed by the decode core.
   typedef struct packed {
      logic [2:0]             bytes_remaining;
      logic [COUNT_WIDTH-1:0] char_count;
   } core_status_type;

   // Saturation point of the code-point counter for a given string bound.
   function automatic logic [COUNT_WIDTH-1:0] count_cap(input int max_bytes);
      return COUNT_WIDTH'((max_bytes < COUNT_LIMIT) ? max_bytes : COUNT_LIMIT);
   endfunction

endpackage

### sv/utdec_stream_if.sv
// Valid/ready stream interface carrying one payload beat.
interface utdec_stream_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

### sv/utdec_pipe_reg.sv
// Register slice with valid/ready flow control for one payload beat.
module utdec_pipe_reg #(
   parameter type payload_type = logic
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  payload_type in_payload,
   output logic        out_valid,
   input  logic        out_ready,
   output payload_type out_payload
);

   logic        valid_ff;
   logic        valid_in;
   payload_type payload_ff;

   // The slot is free when empty or when its beat leaves this cycle.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload loads whenever a new beat enters; no reset needed.
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         payload_ff <= in_payload;
      end
   end

   assign out_valid   = valid_ff;
   assign out_payload = payload_ff;

endmodule

### sv/utdec_core.sv
// Decode logic and sequence state: classifies a byte, gathers bits, counts code points.
module utdec_core #(
   parameter int MAX_STRING_BYTES = utdec_pkg::MAX_STRING_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [utdec_pkg::CP_WIDTH-1:0]   csr_wr_data,
   input  utdec_pkg::req_payload_type       item,
   input  logic                             commit,
   output logic                             have_result,
   output utdec_pkg::rsp_payload_type       result,
   output utdec_pkg::core_status_type       status
);

   localparam logic [utdec_pkg::COUNT_WIDTH-1:0] COUNT_CAP =
      utdec_pkg::count_cap(MAX_STRING_BYTES);

   logic [utdec_pkg::CP_WIDTH-1:0]    replacement_ff;
   logic [2:0]                        remaining_ff, remaining_in;
   logic [2:0]                        taken_ff, taken_in;
   logic [utdec_pkg::CP_WIDTH-1:0]    acc_ff, acc_in;
   logic [utdec_pkg::COUNT_WIDTH-1:0] count_ff, count_in;

   logic [7:0]                        b;
   logic [utdec_pkg::CP_WIDTH-1:0]    cont_bits;
   logic [utdec_pkg::CP_WIDTH-1:0]    acc_merged;
   logic [utdec_pkg::CP_WIDTH-1:0]    cp;
   logic                              have;
   logic [2:0]                        remaining_nx;
   logic [2:0]                        taken_nx;
   logic [utdec_pkg::CP_WIDTH-1:0]    acc_nx;
   logic [utdec_pkg::COUNT_WIDTH-1:0] count_nx;

   assign b = item.in_byte;

   // Continuation payload placed by the number of bytes still due.
   always_comb begin
      cont_bits = {{(utdec_pkg::CP_WIDTH-6){1'b0}}, b[5:0] & utdec_pkg::CONT_MASK[5:0]};
      unique case (remaining_ff)
         3'd2:    cont_bits = cont_bits << 6;
         3'd3:    cont_bits = cont_bits << 12;
         3'd4:    cont_bits = cont_bits << 18;
         3'd5:    cont_bits = cont_bits << 24;
         default: cont_bits = cont_bits;
      endcase
   end

   assign acc_merged = acc_ff | cont_bits;

   // Lead classification or continuation merge.
   always_comb begin
      remaining_nx = remaining_ff;
      taken_nx     = taken_ff;
      acc_nx       = acc_ff;
      cp           = '0;
      have         = 1'b0;
      if (remaining_ff == 3'd0) begin
         priority if ((b & utdec_pkg::ASCII_MASK) == 8'h00) begin
            cp   = {23'd0, b};
            have = 1'b1;
         end else if ((b & utdec_pkg::LEAD2_MASK) == utdec_pkg::LEAD2_CODE) begin
            acc_nx       = {20'd0, b[4:0], 6'd0};
            remaining_nx = 3'd1;
            taken_nx     = 3'd1;
         end else if ((b & utdec_pkg::LEAD3_MASK) == utdec_pkg::LEAD3_CODE) begin
            acc_nx       = {15'd0, b[3:0], 12'd0};
            remaining_nx = 3'd2;
            taken_nx     = 3'd1;
         end else if ((b & utdec_pkg::LEAD4_MASK) == utdec_pkg::LEAD4_CODE) begin
            acc_nx       = {10'd0, b[2:0], 18'd0};
            remaining_nx = 3'd3;
            taken_nx     = 3'd1;
         end else if ((b & utdec_pkg::LEAD5_MASK) == utdec_pkg::LEAD5_CODE) begin
            acc_nx       = {5'd0, b[1:0], 24'd0};
            remaining_nx = 3'd4;
            taken_nx     = 3'd1;
         end else if ((b & utdec_pkg::LEAD6_MASK) == utdec_pkg::LEAD6_CODE) begin
            acc_nx       = {b[0], 30'd0};
            remaining_nx = 3'd5;
            taken_nx     = 3'd1;
         end else begin
            // Stray continuation byte or 0xFE/0xFF as a lead.
            cp   = replacement_ff;
            have = 1'b1;
         end
      end else begin
         remaining_nx = remaining_ff - 3'd1;
         taken_nx     = taken_ff + 3'd1;
         if (remaining_ff == 3'd1) begin
            cp       = acc_merged;
            have     = 1'b1;
            acc_nx   = '0;
            taken_nx = 3'd0;
         end else begin
            acc_nx = acc_merged;
         end
      end
   end

   // Saturating code-point count.
   assign count_nx = (have && (count_ff < COUNT_CAP)) ? count_ff + 1'b1 : count_ff;

   // Result beat and end-of-string handling.
   always_comb begin
      result       = '0;
      have_result  = have || item.end_of_string;
      remaining_in = remaining_nx;
      taken_in     = taken_nx;
      acc_in       = acc_nx;
      count_in     = count_nx;
      if (item.end_of_string) begin
         result.last        = 1'b1;
         result.total_chars = count_nx;
         if (have) begin
            result.code_point = cp;
         end else begin
            result.incomplete    = 1'b1;
            result.partial_bytes = taken_nx;
         end
         remaining_in = 3'd0;
         taken_in     = 3'd0;
         acc_in       = '0;
         count_in     = '0;
      end else begin
         result.code_point = cp;
      end
   end

   // Sequence state advances only when the staged byte is consumed.
   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= 3'd0;
         taken_ff     <= 3'd0;
         acc_ff       <= '0;
         count_ff     <= '0;
      end else if (commit) begin
         remaining_ff <= remaining_in;
         taken_ff     <= taken_in;
         acc_ff       <= acc_in;
         count_ff     <= count_in;
      end
   end

   // Replacement character register.
   always_ff @(posedge clock) begin
      if (reset) begin
         replacement_ff <= utdec_pkg::REPLACEMENT_RESET;
      end else if (csr_wr_en) begin
         replacement_ff <= csr_wr_data;
      end
   end

   assign status.bytes_remaining = remaining_ff;
   assign status.char_count      = count_ff;

endmodule

### sv/utf8_to_ucs4_decoder.sv
// Top level of the UTF-8 to UCS-4 stream decoder.
//
//   Channel  Dir  Payload                                               Handshake
//   req_if   in   in_byte[7:0], end_of_string                           valid/ready
//   rsp_if   out  code_point[30:0], incomplete, partial_bytes[2:0],     valid/ready
//                 total_chars[16:0], last
//   csr_*    in   csr_wr_data[30:0] (replacement character)             csr_wr_en
//
// One byte is accepted per cycle while no stall on rsp_if holds the staged byte. A byte
// waits in the input register, where the decode logic runs, and its result is loaded
// into the result register when the byte is consumed; that register drives rsp_if.valid.
// Synchronous reset clears both registers' valid bits and the sequence state,
// and restores the replacement character to U+FFFD.
// A stall on rsp_if holds the staged byte only if it produces a result; bytes
// that only open or extend a sequence keep flowing.
module utf8_to_ucs4_decoder #(
   parameter int MAX_STRING_BYTES = utdec_pkg::MAX_STRING_BYTES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   utdec_stream_if.sink                   req_if,
   utdec_stream_if.source                 rsp_if,
   input  logic                           csr_wr_en,
   input  logic [utdec_pkg::CP_WIDTH-1:0] csr_wr_data
);

   localparam logic [utdec_pkg::COUNT_WIDTH-1:0] COUNT_CAP =
      utdec_pkg::count_cap(MAX_STRING_BYTES);

   logic                        stage_valid;
   logic                        stage_ready;
   utdec_pkg::req_payload_type  stage_item;
   logic                        have_result;
   utdec_pkg::rsp_payload_type  result;
   utdec_pkg::core_status_type  status;
   logic                        out_ready;
   logic                        commit;

   // Input register holding the byte under decode.
   utdec_pipe_reg #(
      .payload_type (utdec_pkg::req_payload_type)
   ) u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_if.valid),
      .in_ready    (req_if.ready),
      .in_payload  (req_if.payload),
      .out_valid   (stage_valid),
      .out_ready   (stage_ready),
      .out_payload (stage_item)
   );

   // The staged byte leaves when it has no result or the result slot is free.
   assign stage_ready = !have_result || out_ready;
   assign commit      = stage_valid && stage_ready;

   utdec_core #(
      .MAX_STRING_BYTES (MAX_STRING_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item        (stage_item),
      .commit      (commit),
      .have_result (have_result),
      .result      (result),
      .status      (status)
   );

   // Result register toward the response channel.
   utdec_pipe_reg #(
      .payload_type (utdec_pkg::rsp_payload_type)
   ) u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (stage_valid && have_result),
      .in_ready    (out_ready),
      .in_payload  (result),
      .out_valid   (rsp_if.valid),
      .out_ready   (rsp_if.ready),
      .out_payload (rsp_if.payload)
   );

   // An incomplete beat is always the final one and carries no code point.
   a_incomplete_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.payload.incomplete) |->
         (rsp_if.payload.last && rsp_if.payload.code_point == '0))
      else $error("incomplete result without last or with nonzero code point");

   // Only the final beat reports a count or partial byte number.
   a_mid_string_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.payload.last) |->
         (rsp_if.payload.total_chars == '0 && rsp_if.payload.partial_bytes == 3'd0))
      else $error("count or partial bytes reported before end of string");

   // Consuming an end-of-string byte leaves the decoder at the start of a string.
   a_eos_clears_state: assert property (@(posedge clock) disable iff (reset)
      (commit && stage_item.end_of_string) |=>
         (status.bytes_remaining == 3'd0 && status.char_count == '0))
      else $error("sequence state not cleared after end of string");

   // The count never passes its saturation point.
   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.payload.total_chars <= COUNT_CAP))
      else $error("total_chars beyond saturation limit");

endmodule
